[rtl/lshr_pkg.sv]
// ----------------------------------------------------------------------------
// lshr_pkg
// Shared types and constants for the load statistics history ring.
// ----------------------------------------------------------------------------
package lshr_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_CLOSE  = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  localparam logic [15:0] INTERVAL_RESET = 16'd120;
  localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

  // radix-2 divider: one quotient bit per step
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = 5;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] bandwidth;
    logic [31:0] sessions;
    logic [5:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  entry_count;
    logic [31:0] bw_mean;
    logic [31:0] bw_max;
    logic [31:0] bw_min;
    logic [31:0] sess_mean;
    logic [31:0] sess_max;
    logic [31:0] sess_min;
    logic [15:0] interval_out;
  } out_item_t;

  // one stored history record
  typedef struct packed {
    logic [31:0] bw_mean;
    logic [31:0] bw_max;
    logic [31:0] bw_min;
    logic [31:0] sess_mean;
    logic [31:0] sess_max;
    logic [31:0] sess_min;
  } ring_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DINIT,
    S_DIV,
    S_READ,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic mul;
    logic div_init;
    logic div_step;
    logic rd;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

[rtl/lshr_mean.sv]
// ----------------------------------------------------------------------------
// lshr_mean
// Running mean update unit: registered multiply, then a restoring divide
// that produces one quotient bit per step.
// ----------------------------------------------------------------------------
module lshr_mean
  import lshr_pkg::*;
(
  input  logic        clk,
  input  logic        mul,
  input  logic        init,
  input  logic        step,
  input  logic [31:0] mean,
  input  logic [31:0] sample,
  input  logic [15:0] count,
  output logic [31:0] quo
);

  logic [47:0] prod_r;
  logic [16:0] den_r;
  logic [16:0] rem_r;
  logic [31:0] quo_r;

  logic [48:0] num;
  logic [17:0] trial;
  logic [18:0] diff;
  logic        ge;
  logic [16:0] rem_nxt;
  logic [31:0] quo_nxt;

  always_comb begin
    num     = {1'b0, prod_r} + {17'd0, sample};
    trial   = {rem_r, quo_r[31]};
    diff    = {1'b0, trial} - {2'b00, den_r};
    ge      = ~diff[18];
    rem_nxt = ge ? diff[16:0] : trial[16:0];
    quo_nxt = {quo_r[30:0], ge};
  end

  // quotient fits 32 bits, so the top 17 numerator bits start below the divisor
  always_ff @(posedge clk) begin
    if (mul) begin
      prod_r <= {16'd0, mean} * {32'd0, count};
      den_r  <= {1'b0, count} + 17'd1;
    end
    if (init) begin
      rem_r <= num[48:32];
      quo_r <= num[31:0];
    end else if (step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule

[rtl/lshr_ctrl.sv]
// ----------------------------------------------------------------------------
// lshr_ctrl
// Sequencer: steps one request through multiply, divide, ring read and commit.
// ----------------------------------------------------------------------------
module lshr_ctrl
  import lshr_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  op_t    item_op,
  input  sts_t   sts,
  output logic   in_stall,
  output cmd_t   cmd
);

  state_t                 state_r, state_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch = 1'b1;
          case (item_op)
            OP_SAMPLE: state_nxt = S_MUL;
            OP_READ:   state_nxt = S_READ;
            default:   state_nxt = S_FINISH;
          endcase
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_FINISH;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/lshr_dp.sv]
// ----------------------------------------------------------------------------
// lshr_dp
// Datapath: accumulators, mean units, history ring, config and output register.
// ----------------------------------------------------------------------------
module lshr_dp
  import lshr_pkg::*;
#(
  parameter int HISTORY_DEPTH = 64
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  in_item_t    in_data,
  input  logic        cfg_valid,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);

  in_item_t    item_r;
  logic [15:0] interval_r;

  logic [31:0] bw_min_r, bw_max_r, bw_mean_r;
  logic [31:0] se_min_r, se_max_r, se_mean_r;
  logic [15:0] count_r;
  logic [AW-1:0] cursor_r;
  logic [CW-1:0] fill_r;

  logic [31:0] bw_min_nxt, bw_max_nxt, bw_mean_nxt;
  logic [31:0] se_min_nxt, se_max_nxt, se_mean_nxt;
  logic [15:0] count_nxt;
  logic [AW-1:0] cursor_nxt;
  logic [CW-1:0] fill_nxt;

  logic        out_valid_r;
  out_item_t   out_r, out_nxt;

  ring_entry_t ring_mem [HISTORY_DEPTH];
  ring_entry_t rd_data_r;
  ring_entry_t wr_data;
  logic        wr_en;

  logic [31:0] bw_quo, se_quo;
  logic [31:0] idx32, sum32, fill32, fill_nxt32;
  logic [AW-1:0] phys;
  logic        first;

  lshr_mean u_bw_mean (
    .clk    (clk),
    .mul    (cmd.mul),
    .init   (cmd.div_init),
    .step   (cmd.div_step),
    .mean   (bw_mean_r),
    .sample (item_r.bandwidth),
    .count  (count_r),
    .quo    (bw_quo)
  );

  lshr_mean u_se_mean (
    .clk    (clk),
    .mul    (cmd.mul),
    .init   (cmd.div_init),
    .step   (cmd.div_step),
    .mean   (se_mean_r),
    .sample (item_r.sessions),
    .count  (count_r),
    .quo    (se_quo)
  );

  assign sts.out_free = ~out_valid_r | ~out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

  // oldest-first position to ring slot
  always_comb begin
    idx32  = 32'(item_r.read_index);
    fill32 = 32'(fill_r);
    sum32  = 32'(cursor_r) + idx32;
    if (fill_r == CW'(HISTORY_DEPTH)) begin
      if (sum32 >= 32'(HISTORY_DEPTH)) begin
        sum32 = sum32 - 32'(HISTORY_DEPTH);
      end
      phys = sum32[AW-1:0];
    end else begin
      phys = idx32[AW-1:0];
    end
  end

  always_comb begin
    first       = (count_r == 16'd0);
    bw_min_nxt  = bw_min_r;
    bw_max_nxt  = bw_max_r;
    bw_mean_nxt = bw_mean_r;
    se_min_nxt  = se_min_r;
    se_max_nxt  = se_max_r;
    se_mean_nxt = se_mean_r;
    count_nxt   = count_r;
    cursor_nxt  = cursor_r;
    fill_nxt    = fill_r;
    wr_en       = 1'b0;
    wr_data     = {bw_mean_r, bw_max_r, bw_min_r, se_mean_r, se_max_r, se_min_r};
    out_nxt     = '0;
    out_nxt.status = STAT_OK;

    case (op_t'(item_r.op))
      OP_SAMPLE: begin
        if (first || (item_r.bandwidth < bw_min_r)) bw_min_nxt = item_r.bandwidth;
        if (first || (item_r.sessions < se_min_r))  se_min_nxt = item_r.sessions;
        if (item_r.bandwidth > bw_max_r) bw_max_nxt = item_r.bandwidth;
        if (item_r.sessions > se_max_r)  se_max_nxt = item_r.sessions;
        bw_mean_nxt = bw_quo;
        se_mean_nxt = se_quo;
        if (count_r != COUNT_MAX) count_nxt = count_r + 16'd1;
        out_nxt.bw_mean   = bw_mean_nxt;
        out_nxt.bw_max    = bw_max_nxt;
        out_nxt.bw_min    = bw_min_nxt;
        out_nxt.sess_mean = se_mean_nxt;
        out_nxt.sess_max  = se_max_nxt;
        out_nxt.sess_min  = se_min_nxt;
      end
      OP_CLOSE: begin
        if (first) begin
          out_nxt.status = STAT_EMPTY;
        end else begin
          wr_en = 1'b1;
          cursor_nxt = (cursor_r == AW'(HISTORY_DEPTH - 1)) ? '0 : cursor_r + 1'b1;
          if (fill_r != CW'(HISTORY_DEPTH)) fill_nxt = fill_r + 1'b1;
          out_nxt.bw_mean   = bw_mean_r;
          out_nxt.bw_max    = bw_max_r;
          out_nxt.bw_min    = bw_min_r;
          out_nxt.sess_mean = se_mean_r;
          out_nxt.sess_max  = se_max_r;
          out_nxt.sess_min  = se_min_r;
          bw_min_nxt  = '0;
          bw_max_nxt  = '0;
          bw_mean_nxt = '0;
          se_min_nxt  = '0;
          se_max_nxt  = '0;
          se_mean_nxt = '0;
          count_nxt   = '0;
        end
      end
      OP_READ: begin
        if (idx32 >= fill32) begin
          out_nxt.status = STAT_RANGE;
        end else begin
          out_nxt.bw_mean   = rd_data_r.bw_mean;
          out_nxt.bw_max    = rd_data_r.bw_max;
          out_nxt.bw_min    = rd_data_r.bw_min;
          out_nxt.sess_mean = rd_data_r.sess_mean;
          out_nxt.sess_max  = rd_data_r.sess_max;
          out_nxt.sess_min  = rd_data_r.sess_min;
        end
      end
      default: begin
        out_nxt.bw_mean   = bw_mean_r;
        out_nxt.bw_max    = bw_max_r;
        out_nxt.bw_min    = bw_min_r;
        out_nxt.sess_mean = se_mean_r;
        out_nxt.sess_max  = se_max_r;
        out_nxt.sess_min  = se_min_r;
      end
    endcase

    fill_nxt32           = 32'(fill_nxt);
    out_nxt.entry_count  = fill_nxt32[6:0];
    out_nxt.interval_out = interval_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r  <= INTERVAL_RESET;
      bw_min_r    <= '0;
      bw_max_r    <= '0;
      bw_mean_r   <= '0;
      se_min_r    <= '0;
      se_max_r    <= '0;
      se_mean_r   <= '0;
      count_r     <= '0;
      cursor_r    <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        interval_r <= cfg_data;
      end
      if (cmd.commit) begin
        bw_min_r    <= bw_min_nxt;
        bw_max_r    <= bw_max_nxt;
        bw_mean_r   <= bw_mean_nxt;
        se_min_r    <= se_min_nxt;
        se_max_r    <= se_max_nxt;
        se_mean_r   <= se_mean_nxt;
        count_r     <= count_nxt;
        cursor_r    <= cursor_nxt;
        fill_r      <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_data;
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  // history ring
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      ring_mem[cursor_r] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data_r <= ring_mem[phys];
    end
  end

endmodule

[rtl/load_stats_history_ring.sv]
// ----------------------------------------------------------------------------
// load_stats_history_ring
// Load monitor: running min/max/mean of bandwidth and sessions, closed into a
// ring of history records that can be read back oldest first.
// ----------------------------------------------------------------------------
// latency path: sample MUL, DINIT, DIV, FINISH; read READ, FINISH; other FINISH
// one request at a time, taken again after its commit; sample time is set by the
//   32-step radix-2 divider in each mean unit, reads by the ring read port
// an output register holds the result, so a new request can start while it waits
// reset (rst_n, synchronous): accumulators, cursor and fill count clear,
//   interval returns to 120; ring contents are not cleared and need no pass
module load_stats_history_ring
  import lshr_pkg::*;
#(
  parameter int HISTORY_DEPTH = 64
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  lshr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .item_op  (op_t'(in_data.op)),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  lshr_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[dv/tb_load_stats_history_ring.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_load_stats_history_ring
// Self-checking bench for the load statistics history ring. A directed table
// hits the corner cases: empty close, read past fill and extremes. Random
// requests then run under several interval settings. Every result is compared
// field by field against a typed-in expectation or an in-bench copy of the
// windowed min/max/mean and history ring.
// ----------------------------------------------------------------------------
module tb_load_stats_history_ring;
  import lshr_pkg::*;

  localparam int DEPTH       = 64;
  localparam int PHASE_ITEMS = 165;
  localparam int DRAIN_LIMIT = 20000;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_PRINTS  = 100;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } row_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data  = '0;

  // sideband that travels with in_data: a typed-in expectation, if any
  logic        tag_typed = 1'b0;
  out_item_t   tag_want  = '0;

  // bench copy of the block state
  ring_entry_t win;
  logic [15:0] win_n;
  ring_entry_t hist [DEPTH];
  int          hist_wr;
  int          hist_fill;
  logic [15:0] interval_reg;

  out_item_t   due_results [$];
  row_t        plan_q [$];

  // generator view of the ring, kept from the request stream alone
  bit          gen_open;
  int          gen_fill;

  int errors, n_checked, n_samp, n_close, n_stored, n_read, n_range, n_idle_ops;
  int n_cfg;
  logic [9:0] stall_tick = '0;

  load_stats_history_ring #(
    .HISTORY_DEPTH(DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] mean_step(logic [31:0] avg, logic [31:0] x,
                                            logic [15:0] n);
    logic [63:0] num;
    logic [63:0] den;
    num = 64'(x) + 64'(avg) * 64'(n);
    den = 64'(n) + 64'd1;
    return 32'(num / den);
  endfunction

  // advance the bench state by one request and return the result it causes
  function automatic out_item_t track_request(in_item_t it);
    out_item_t   r;
    ring_entry_t six;
    int          phys;
    r = '0;
    six = '0;
    r.status = STAT_OK;
    case (op_t'(it.op))
      OP_SAMPLE: begin
        n_samp++;
        if (win_n == 16'd0 || it.bandwidth < win.bw_min) win.bw_min = it.bandwidth;
        if (win_n == 16'd0 || it.sessions < win.sess_min) win.sess_min = it.sessions;
        if (it.bandwidth > win.bw_max) win.bw_max = it.bandwidth;
        if (it.sessions > win.sess_max) win.sess_max = it.sessions;
        win.bw_mean   = mean_step(win.bw_mean, it.bandwidth, win_n);
        win.sess_mean = mean_step(win.sess_mean, it.sessions, win_n);
        if (win_n != COUNT_MAX) win_n++;
        six = win;
      end
      OP_CLOSE: begin
        n_close++;
        if (win_n == 16'd0) begin
          r.status = STAT_EMPTY;
        end else begin
          hist[hist_wr] = win;
          hist_wr = (hist_wr + 1) % DEPTH;
          if (hist_fill < DEPTH) hist_fill++;
          six = win;
          win = '0;
          win_n = 16'd0;
          n_stored++;
        end
      end
      OP_READ: begin
        n_read++;
        if (int'(it.read_index) >= hist_fill) begin
          r.status = STAT_RANGE;
          n_range++;
        end else begin
          // oldest entry sits at the write cursor once the ring is full
          phys = (hist_fill >= DEPTH) ? (hist_wr + int'(it.read_index)) % DEPTH
                                      : int'(it.read_index);
          six = hist[phys];
        end
      end
      default: begin
        n_idle_ops++;
        six = win;
      end
    endcase
    r.entry_count  = 7'(hist_fill);
    r.bw_mean      = six.bw_mean;
    r.bw_max       = six.bw_max;
    r.bw_min       = six.bw_min;
    r.sess_mean    = six.sess_mean;
    r.sess_max     = six.sess_max;
    r.sess_min     = six.sess_min;
    r.interval_out = interval_reg;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("error at result %0d: %s got %0h want %0h", n_checked, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic compare_result(input out_item_t got, input out_item_t want);
    check_field("status", 32'(got.status), 32'(want.status));
    check_field("entry_count", 32'(got.entry_count), 32'(want.entry_count));
    check_field("bw_mean", got.bw_mean, want.bw_mean);
    check_field("bw_max", got.bw_max, want.bw_max);
    check_field("bw_min", got.bw_min, want.bw_min);
    check_field("sess_mean", got.sess_mean, want.sess_mean);
    check_field("sess_max", got.sess_max, want.sess_max);
    check_field("sess_min", got.sess_min, want.sess_min);
    check_field("interval_out", 32'(got.interval_out), 32'(want.interval_out));
  endtask

  // request and result monitor
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && in_valid && !in_stall) begin
      want = track_request(in_data);
      if (tag_typed) want = tag_want;
      due_results.push_back(want);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with no request pending", 32'(out_data.status), 32'd0);
      end else begin
        want = due_results.pop_front();
        compare_result(out_data, want);
      end
      n_checked++;
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      interval_reg = cfg_data;
      n_cfg++;
    end
  end

  // result side backpressure: quiet, light, heavy and long-stall stretches
  always @(posedge clk) begin
    stall_tick <= stall_tick + 10'd1;
    case (stall_tick[9:8])
      2'd0:    out_stall <= 1'b0;
      2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
      2'd2:    out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= (stall_tick[3:0] < 4'd11);
    endcase
  end

  function automatic void add_row(in_item_t item, bit typed, out_item_t want);
    row_t row;
    row.item  = item;
    row.typed = typed;
    row.want  = want;
    plan_q.push_back(row);
    case (op_t'(item.op))
      OP_SAMPLE: gen_open = 1'b1;
      OP_CLOSE: begin
        if (gen_open && gen_fill < DEPTH) gen_fill++;
        gen_open = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t rand_request(op_t op);
    in_item_t it;
    it.op         = op;
    it.bandwidth  = rand_word();
    it.sessions   = rand_word();
    it.read_index = 6'($urandom_range(0, 63));
    // most reads land on stored entries
    if (op == OP_READ && gen_fill != 0 && $urandom_range(0, 3) != 0)
      it.read_index = 6'($urandom_range(0, gen_fill - 1));
    return it;
  endfunction

  // send queued requests in bursts with random gaps
  task automatic send_rows(input bit no_gaps);
    row_t row;
    int   burst;
    int   gap;
    while (plan_q.size() != 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && plan_q.size() != 0) begin
        row = plan_q.pop_front();
        in_data   <= row.item;
        tag_typed <= row.typed;
        tag_want  <= row.want;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst--;
      end
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    int waited;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (due_results.size() != 0 && waited < DRAIN_LIMIT);
  endtask

  task automatic write_interval(input logic [15:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] settings [4];
    int          roll;
    op_t         op;

    win = '0;
    win_n = '0;
    hist_wr = 0;
    hist_fill = 0;
    interval_reg = INTERVAL_RESET;
    settings = '{16'hFFFF, 16'h0000, 16'($urandom), 16'd1};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table at the reset interval
    add_row({OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0}, 1'b1,
            {STAT_RANGE, 7'd0, 192'd0, INTERVAL_RESET});
    add_row({OP_CLOSE, 32'h0, 32'h0, 6'd0}, 1'b1,
            {STAT_EMPTY, 7'd0, 192'd0, INTERVAL_RESET});
    add_row({OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F}, 1'b1,
            {STAT_OK, 7'd0, 192'd0, INTERVAL_RESET});
    add_row({OP_SAMPLE, 32'hFFFF_FFFF, 32'h0, 6'h3F}, 1'b1,
            {STAT_OK, 7'd0, {3{32'hFFFF_FFFF}}, 96'd0, INTERVAL_RESET});
    add_row({OP_SAMPLE, 32'h0, 32'hFFFF_FFFF, 6'd0}, 1'b0, '0);
    add_row({OP_NONE, 32'h0, 32'h0, 6'd0}, 1'b0, '0);
    add_row({OP_CLOSE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F}, 1'b0, '0);
    add_row({OP_CLOSE, 32'h0, 32'h0, 6'd0}, 1'b1,
            {STAT_EMPTY, 7'd1, 192'd0, INTERVAL_RESET});
    add_row({OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0}, 1'b0, '0);
    add_row({OP_READ, 32'h0, 32'h0, 6'd1}, 1'b1,
            {STAT_RANGE, 7'd1, 192'd0, INTERVAL_RESET});
    add_row({OP_READ, 32'h0, 32'h0, 6'h3F}, 1'b1,
            {STAT_RANGE, 7'd1, 192'd0, INTERVAL_RESET});
    add_row({OP_SAMPLE, 32'hAAAA_AAAA, 32'h5555_5555, 6'h15}, 1'b0, '0);
    add_row({OP_SAMPLE, 32'h5555_5555, 32'hAAAA_AAAA, 6'h2A}, 1'b0, '0);
    add_row({OP_SAMPLE, 32'h0000_0001, 32'hFFFF_FFFE, 6'd0}, 1'b0, '0);
    add_row({OP_CLOSE, 32'h0, 32'h0, 6'd0}, 1'b0, '0);
    add_row({OP_READ, 32'h0, 32'h0, 6'd1}, 1'b0, '0);
    add_row({OP_READ, 32'h0, 32'h0, 6'd0}, 1'b0, '0);
    add_row({OP_READ, 32'h0, 32'h0, 6'd2}, 1'b1,
            {STAT_RANGE, 7'd2, 192'd0, INTERVAL_RESET});
    add_row({OP_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF, 6'h3F}, 1'b0, '0);
    add_row({OP_NONE, 32'h1234_5678, 32'h8765_4321, 6'h2A}, 1'b0, '0);
    send_rows(1'b0);
    wait_idle();

    // random traffic, one phase per interval setting
    foreach (settings[s]) begin
      write_interval(settings[s]);
      repeat (PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 45)      op = OP_SAMPLE;
        else if (roll < 65) op = OP_CLOSE;
        else if (roll < 93) op = OP_READ;
        else                op = OP_NONE;
        add_row(rand_request(op), 1'b0, '0);
      end
      send_rows(1'b0);
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_results.size() != 0)
      report_mismatch("results never returned", due_results.size(), 0);

    $display("checked %0d results from %0d samples, %0d closes and %0d reads",
             n_checked, n_samp, n_close, n_read);
    $display("%0d closes stored, %0d reads past fill, %0d no-ops, ring wrapped %0d times, %0d interval writes",
             n_stored, n_range, n_idle_ops, n_stored / DEPTH, n_cfg);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout: %0d results still due", due_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
